// File: hdl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg: palette fade stepper shared definitions
// Colour layout, opcodes, sequencer states and the per-entry step function.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int PALETTE_ENTRIES_DEF = 32;
  localparam int COLOUR_W            = 12;
  localparam int CHAN_W              = 4;
  localparam int INDEX_W             = 5;

  localparam logic [1:0] STEP_PHASE = 2'd3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SWEEP = 1'b1
  } state_t;

  // one channel one step toward its goal
  function automatic logic [CHAN_W-1:0] approach(input logic [CHAN_W-1:0] now,
                                                 input logic [CHAN_W-1:0] goal);
    logic [CHAN_W-1:0] res;
    res = now;
    if (now > goal) begin
      res = now - CHAN_W'(1);
    end else if (now < goal) begin
      res = now + CHAN_W'(1);
    end
    return res;
  endfunction

  function automatic logic [COLOUR_W-1:0] step_colour(input logic [COLOUR_W-1:0] now,
                                                      input logic [COLOUR_W-1:0] goal);
    logic [COLOUR_W-1:0] res;
    res[11:8] = approach(now[11:8], goal[11:8]);
    res[7:4]  = approach(now[7:4], goal[7:4]);
    res[3:0]  = approach(now[3:0], goal[3:0]);
    return res;
  endfunction

endpackage

// File: hdl/palette_fade_stepper.sv
// ----------------------------------------------------------------------------
// palette_fade_stepper: RGB444 palette fader
// Current and target palettes in two synchronous memories; a fade tick walks
// every entry, steps it toward its target and writes one word per entry.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries either a target colour write
// (opcode 0) or a frame tick (opcode 1). A write gives no output. A tick with
// fade_enable set and frame_phase == 3 starts a sweep: entries are read from
// both memories one per cycle while the output is not stalled, stepped,
// written back to the current palette and presented on the output channel
// (out_valid/out_stall) in index order, last_of_run on the final one.
// The single read port of each memory sets the one-entry-per-cycle pace.
// After the tick is accepted, each entry is read into the memory output
// registers, stepped and loaded into the output register. The input is
// stalled from tick acceptance until the last entry has been read and
// loaded into the output register; the last word may still wait there while
// the next item is taken. An output stall freezes the sweep with the pending
// read held, so no word is lost. Other ticks start no sweep.
// Reset (rst, synchronous) clears both palettes to black through per-entry
// valid bits, clears fade_enable and empties the pipeline; no clearing pass.
// ----------------------------------------------------------------------------
module palette_fade_stepper #(
  parameter int PALETTE_ENTRIES = pfs_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [pfs_pkg::INDEX_W-1:0]   entry_index,
  input  logic [pfs_pkg::COLOUR_W-1:0]  target_colour,
  input  logic [1:0]                    frame_phase,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfs_pkg::INDEX_W-1:0]   colour_index,
  output logic [pfs_pkg::COLOUR_W-1:0]  colour_value,
  output logic                          last_of_run
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  pfs_pkg::state_t state, state_next;

  logic                          fade_enable;
  logic [IDX_W-1:0]              rd_idx;
  logic                          rd_issue;
  logic                          rd_pend;
  logic [IDX_W-1:0]              pend_idx;
  logic                          pend_last;
  logic                          load_out;
  logic                          in_accept;
  logic                          step_go;
  logic                          tgt_wr;

  logic [pfs_pkg::COLOUR_W-1:0]  cur_mem [PALETTE_ENTRIES];
  logic [pfs_pkg::COLOUR_W-1:0]  tgt_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0]    cur_ok;
  logic [PALETTE_ENTRIES-1:0]    tgt_ok;
  logic [pfs_pkg::COLOUR_W-1:0]  cur_q, tgt_q;
  logic                          cur_q_ok, tgt_q_ok;
  logic [pfs_pkg::COLOUR_W-1:0]  cur_now, tgt_now, stepped;

  assign in_accept = in_valid & ~in_stall;
  assign step_go   = in_accept && (opcode == pfs_pkg::OP_TICK) && fade_enable &&
                     (frame_phase == pfs_pkg::STEP_PHASE);
  assign tgt_wr    = in_accept && (opcode == pfs_pkg::OP_WRITE) &&
                     (32'(entry_index) < PALETTE_ENTRIES);
  assign load_out  = rd_pend && (~out_valid || ~out_stall);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      fade_enable <= cfg_wr_data;
    end
  end

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      pfs_pkg::ST_IDLE: begin
        if (step_go) state_next = pfs_pkg::ST_SWEEP;
      end
      pfs_pkg::ST_SWEEP: begin
        if (rd_issue && rd_idx == LAST_IDX) state_next = pfs_pkg::ST_IDLE;
      end
      default: state_next = pfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_issue = 1'b0;
    in_stall = rd_pend;
    unique case (state)
      pfs_pkg::ST_IDLE: begin
        rd_issue = 1'b0;
      end
      pfs_pkg::ST_SWEEP: begin
        rd_issue = ~rd_pend | load_out;
        in_stall = 1'b1;
      end
      default: begin
        rd_issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pfs_pkg::ST_IDLE;
      rd_idx  <= '0;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (step_go) begin
        rd_idx <= '0;
      end else if (rd_issue) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
      if (rd_issue) begin
        rd_pend <= 1'b1;
      end else if (load_out) begin
        rd_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      pend_idx  <= rd_idx;
      pend_last <= (rd_idx == LAST_IDX);
    end
  end

  // ------------------------------------------------------------- memories
  // entries never written read as black
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ok <= '0;
      tgt_ok <= '0;
    end else begin
      if (load_out) cur_ok[pend_idx] <= 1'b1;
      if (tgt_wr)   tgt_ok[IDX_W'(entry_index)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cur_mem[pend_idx] <= stepped;
    end
    if (rd_issue) begin
      cur_q    <= cur_mem[rd_idx];
      cur_q_ok <= cur_ok[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (tgt_wr) begin
      tgt_mem[IDX_W'(entry_index)] <= target_colour;
    end
    if (rd_issue) begin
      tgt_q    <= tgt_mem[rd_idx];
      tgt_q_ok <= tgt_ok[rd_idx];
    end
  end

  assign cur_now = cur_q_ok ? cur_q : '0;
  assign tgt_now = tgt_q_ok ? tgt_q : '0;
  assign stepped = pfs_pkg::step_colour(cur_now, tgt_now);

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      colour_index <= pfs_pkg::INDEX_W'(pend_idx);
      colour_value <= stepped;
      last_of_run  <= pend_last;
    end
  end

  // ------------------------------------------------------------ assertions
  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    step_go |=> (state == pfs_pkg::ST_SWEEP && rd_idx == '0))
    else $error("sweep did not start at entry zero");

  a_no_raw_hazard: assert property (@(posedge clk) disable iff (rst)
    (load_out && rd_issue) |-> (rd_idx != pend_idx))
    else $error("read and writeback hit the same entry");

  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    (rd_pend && !load_out) |=> (rd_pend && $stable(pend_idx)))
    else $error("pending entry dropped while output stalled");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_run) |-> (colour_index == pfs_pkg::INDEX_W'(LAST_IDX)))
    else $error("last_of_run on wrong entry");

endmodule

// File: tb/palette_fade_stepper_tb.sv
// ----------------------------------------------------------------------------
// palette_fade_stepper_tb: self-checking bench for the RGB444 palette fader
// Drives target writes and frame ticks with random gaps and output stalls,
// mirrors both palettes and the enable bit, and checks every colour word.
// ----------------------------------------------------------------------------
module palette_fade_stepper_tb;

  localparam int ENTRIES      = pfs_pkg::PALETTE_ENTRIES_DEF;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [pfs_pkg::INDEX_W-1:0]  index;
    logic [pfs_pkg::COLOUR_W-1:0] value;
    logic                         last;
  } colour_write_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  logic                         cfg_wr_data = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         opcode = 1'b0;
  logic [pfs_pkg::INDEX_W-1:0]  entry_index = '0;
  logic [pfs_pkg::COLOUR_W-1:0] target_colour = '0;
  logic [1:0]                   frame_phase = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [pfs_pkg::INDEX_W-1:0]  colour_index;
  logic [pfs_pkg::COLOUR_W-1:0] colour_value;
  logic                         last_of_run;

  // mirror of the block state
  logic [pfs_pkg::COLOUR_W-1:0] shadow_current [ENTRIES];
  logic [pfs_pkg::COLOUR_W-1:0] shadow_target [ENTRIES];
  bit                           shadow_fade_en = 1'b0;

  colour_write_t pending_colour_writes[$];
  int            error_count = 0;
  bit            idle_on = 1'b1;

  always #5 clk = ~clk;

  palette_fade_stepper u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .entry_index   (entry_index),
    .target_colour (target_colour),
    .frame_phase   (frame_phase),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .colour_index  (colour_index),
    .colour_value  (colour_value),
    .last_of_run   (last_of_run)
  );

  // each 4-bit channel moves one step toward its goal
  function automatic logic [pfs_pkg::COLOUR_W-1:0] fade_one_step(
    input logic [pfs_pkg::COLOUR_W-1:0] now,
    input logic [pfs_pkg::COLOUR_W-1:0] goal);
    logic [pfs_pkg::COLOUR_W-1:0] res;
    int                           c;
    res = now;
    for (c = 0; c < pfs_pkg::COLOUR_W; c += 4) begin
      if (goal[c+:4] > now[c+:4]) begin
        res[c+:4] = now[c+:4] + 4'd1;
      end else if (goal[c+:4] < now[c+:4]) begin
        res[c+:4] = now[c+:4] - 4'd1;
      end
    end
    return res;
  endfunction

  task automatic update_palette_model(input pfs_pkg::opcode_t op,
                                      input logic [pfs_pkg::INDEX_W-1:0] idx,
                                      input logic [pfs_pkg::COLOUR_W-1:0] colour,
                                      input logic [1:0] phase);
    colour_write_t w;
    if (op == pfs_pkg::OP_WRITE) begin
      if (int'(idx) < ENTRIES) begin
        shadow_target[idx] = colour;
      end
    end else if (shadow_fade_en && phase == pfs_pkg::STEP_PHASE) begin
      for (int i = 0; i < ENTRIES; i++) begin
        shadow_current[i] = fade_one_step(shadow_current[i], shadow_target[i]);
        w.index = pfs_pkg::INDEX_W'(i);
        w.value = shadow_current[i];
        w.last  = (i == ENTRIES - 1);
        pending_colour_writes.push_back(w);
      end
    end
  endtask

  task automatic send_word(input pfs_pkg::opcode_t op,
                           input logic [pfs_pkg::INDEX_W-1:0] idx,
                           input logic [pfs_pkg::COLOUR_W-1:0] colour,
                           input logic [1:0] phase);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    entry_index   <= idx;
    target_colour <= colour;
    frame_phase   <= phase;
    do @(posedge clk); while (in_stall);
    update_palette_model(op, idx, colour, phase);
  endtask

  // input low, all words back, then let the sweep pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_colour_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_fade(input bit en);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    shadow_fade_en = en;
  endtask

  task automatic random_word();
    int                           pick;
    logic [pfs_pkg::COLOUR_W-1:0] colour;
    pick   = $urandom_range(0, 99);
    colour = pfs_pkg::COLOUR_W'($urandom_range(0, 4095));
    if ($urandom_range(0, 7) == 0) begin
      colour = $urandom_range(0, 1) ? 12'hfff : 12'h000;
    end
    if (pick < 68) begin
      send_word(pfs_pkg::OP_WRITE, pfs_pkg::INDEX_W'($urandom_range(0, 31)), colour,
                2'($urandom_range(0, 3)));
    end else if (pick < 93) begin
      send_word(pfs_pkg::OP_TICK, pfs_pkg::INDEX_W'($urandom_range(0, 31)), colour,
                pfs_pkg::STEP_PHASE);
    end else begin
      send_word(pfs_pkg::OP_TICK, pfs_pkg::INDEX_W'($urandom_range(0, 31)), colour,
                2'($urandom_range(0, 2)));
    end
  endtask

  // extremes written, ticks while fading is off give nothing
  task automatic test_disabled_fade();
    set_fade(1'b0);
    send_word(pfs_pkg::OP_WRITE, 5'd0, 12'hfff, 2'd3);
    send_word(pfs_pkg::OP_WRITE, 5'd31, 12'hfff, 2'd0);
    send_word(pfs_pkg::OP_WRITE, 5'd5, 12'hf0a, 2'd1);
    send_word(pfs_pkg::OP_WRITE, 5'd10, 12'h5a5, 2'd2);
    send_word(pfs_pkg::OP_TICK, 5'd0, 12'h000, pfs_pkg::STEP_PHASE);
    send_word(pfs_pkg::OP_TICK, 5'd31, 12'hfff, 2'd0);
  endtask

  // fading on: only phase 3 steps; tick index and colour are don't-care
  task automatic test_phase_gate();
    set_fade(1'b1);
    send_word(pfs_pkg::OP_TICK, 5'd31, 12'hfff, 2'd0);
    send_word(pfs_pkg::OP_TICK, 5'd0, 12'hfff, 2'd1);
    send_word(pfs_pkg::OP_TICK, 5'd17, 12'h000, 2'd2);
    send_word(pfs_pkg::OP_TICK, 5'd31, 12'hfff, pfs_pkg::STEP_PHASE);
  endtask

  // 0 -> f takes 15 steps; extra steps must hold once channels match
  task automatic test_saturate();
    repeat (15) send_word(pfs_pkg::OP_TICK, pfs_pkg::INDEX_W'($urandom_range(0, 31)),
                          pfs_pkg::COLOUR_W'($urandom_range(0, 4095)),
                          pfs_pkg::STEP_PHASE);
  endtask

  task automatic test_random_traffic(input int count, input bit fade_on);
    set_fade(fade_on);
    for (int n = 0; n < count; n++) begin
      if (n % 20 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      random_word();
    end
  endtask

  task automatic test_no_idle_run(input int count);
    drain();
    idle_on = 1'b0;
    repeat (count) random_word();
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_current[i] = '0;
      shadow_target[i]  = '0;
    end
  end

  // output stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_words
    colour_write_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_colour_writes.size() == 0) begin
        $error("unexpected word: colour_index %0d colour_value %h last_of_run %0b",
               colour_index, colour_value, last_of_run);
        error_count++;
      end else begin
        want = pending_colour_writes.pop_front();
        if (colour_index !== want.index) begin
          $error("colour_index: expected %0d, actual %0d", want.index, colour_index);
          error_count++;
        end
        if (colour_value !== want.value) begin
          $error("colour_value: expected %h, actual %h", want.value, colour_value);
          error_count++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_disabled_fade();
    test_phase_gate();
    test_saturate();
    test_random_traffic(130, 1'b1);
    test_random_traffic(40, 1'b0);
    test_random_traffic(130, 1'b1);
    test_no_idle_run(130);
    drain();
    if (error_count == 0 && pending_colour_writes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
hdl/pfs_pkg.sv
hdl/palette_fade_stepper.sv
tb/palette_fade_stepper_tb.sv
